[design/dfc_pkg.sv]
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared types, register map and CRC-8 helper for the DLE framer.
// ----------------------------------------------------------------------------
package dfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBeats = 8;
  localparam int unsigned BeatIdxW = $clog2(MaxBeats);
  localparam int unsigned CountW   = $clog2(MaxBeats + 1);
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [ByteW-1:0] CrcPoly     = 8'b0011_0001;
  localparam logic [ByteW-1:0] CrcInit     = 8'h00;
  localparam logic [ByteW-1:0] EscapeReset = 8'h10;
  localparam logic [ByteW-1:0] StartReset  = 8'h02;
  localparam logic [ByteW-1:0] EndReset    = 8'h03;

  typedef enum logic [1:0] {
    RegEscape = 2'd0,
    RegStart  = 2'd1,
    RegEnd    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
  } cfg_t;

  // one input item expanded into its output bytes
  typedef struct packed {
    logic [MaxBeats-1:0][ByteW-1:0] bytes;
    logic [BeatIdxW-1:0]            last_idx;
  } burst_t;

  // CRC-8, MSB first, no reflection
  function automatic logic [ByteW-1:0] crc8_fold(logic [ByteW-1:0] crc_in,
                                                 logic [ByteW-1:0] data);
    logic [ByteW-1:0] crc;
    logic             fb;
    crc = crc_in;
    for (int i = 0; i < ByteW; i++) begin
      fb  = data[ByteW-1-i] ^ crc[ByteW-1];
      crc = {crc[ByteW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return crc;
  endfunction

endpackage

[design/dfc_if.sv]
// ----------------------------------------------------------------------------
// dfc_if
// Valid/ready stream interfaces for payload input and framed output.
// ----------------------------------------------------------------------------
interface dfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output first_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input first_byte,
                  input last_byte, output ready);
endinterface

interface dfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

[design/dfc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dfc_cfg_regs
// APB register file: escape, start and end codes.
// ----------------------------------------------------------------------------
module dfc_cfg_regs
  import dfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        RegEscape: cfg_d.escape_code = pwdata[ByteW-1:0];
        RegStart:  cfg_d.start_code  = pwdata[ByteW-1:0];
        RegEnd:    cfg_d.end_code    = pwdata[ByteW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      RegEscape: prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.escape_code};
      RegStart:  prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.start_code};
      RegEnd:    prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.end_code};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{escape_code: EscapeReset, start_code: StartReset, end_code: EndReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/dfc_frame_build.sv]
// ----------------------------------------------------------------------------
// dfc_frame_build
// Input register, CRC state and expansion of one item into its output bytes.
// ----------------------------------------------------------------------------
module dfc_frame_build
  import dfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  dfc_in_if.sink    in_i,
  input  logic      free_i,
  output logic      load_o,
  output burst_t    burst_o
);

  logic             full_q, full_d;
  logic [ByteW-1:0] data_q;
  logic             first_q, last_q;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] crc_new;
  logic             accept;
  logic [CountW-1:0] n;

  assign in_i.ready = !full_q || free_i;
  assign accept     = in_i.valid && in_i.ready;
  assign load_o     = full_q && free_i;

  assign crc_new = crc8_fold(first_q ? CrcInit : crc_q, data_q);

  always_comb begin
    crc_d = crc_q;
    if (load_o) begin
      crc_d = crc_new;
    end
  end

  always_comb begin
    full_d = full_q;
    if (accept) begin
      full_d = 1'b1;
    end else if (load_o) begin
      full_d = 1'b0;
    end
  end

  // pack bytes in send order; n never exceeds MaxBeats
  always_comb begin
    burst_o.bytes = '0;
    n = '0;
    if (first_q) begin
      burst_o.bytes[n[BeatIdxW-1:0]] = cfg_i.escape_code;
      n = n + CountW'(1);
      burst_o.bytes[n[BeatIdxW-1:0]] = cfg_i.start_code;
      n = n + CountW'(1);
    end
    burst_o.bytes[n[BeatIdxW-1:0]] = data_q;
    n = n + CountW'(1);
    if (data_q == cfg_i.escape_code) begin
      burst_o.bytes[n[BeatIdxW-1:0]] = data_q;
      n = n + CountW'(1);
    end
    if (last_q) begin
      burst_o.bytes[n[BeatIdxW-1:0]] = crc_new;
      n = n + CountW'(1);
      if (crc_new == cfg_i.escape_code) begin
        burst_o.bytes[n[BeatIdxW-1:0]] = crc_new;
        n = n + CountW'(1);
      end
      burst_o.bytes[n[BeatIdxW-1:0]] = cfg_i.escape_code;
      n = n + CountW'(1);
      burst_o.bytes[n[BeatIdxW-1:0]] = cfg_i.end_code;
      n = n + CountW'(1);
    end
    burst_o.last_idx = BeatIdxW'(n - CountW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      crc_q  <= CrcInit;
    end else begin
      full_q <= full_d;
      crc_q  <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= in_i.payload_byte;
      first_q <= in_i.first_byte;
      last_q  <= in_i.last_byte;
    end
  end

endmodule

[design/dfc_emit.sv]
// ----------------------------------------------------------------------------
// dfc_emit
// Result register holding one expanded item, sent one byte per beat.
// ----------------------------------------------------------------------------
module dfc_emit
  import dfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       free_o,
  dfc_out_if.source  out_o
);

  logic                valid_q, valid_d;
  logic [BeatIdxW-1:0] idx_q, idx_d;
  burst_t              burst_q;
  logic                at_last;
  logic                beat;

  assign at_last       = idx_q == burst_q.last_idx;
  assign beat          = out_o.valid && out_o.ready;
  assign free_o        = !valid_q || (out_o.ready && at_last);
  assign out_o.valid   = valid_q;
  assign out_o.out_byte = burst_q.bytes[idx_q];
  assign out_o.run_end = at_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (beat && at_last) begin
      valid_d = 1'b0;
    end else if (beat) begin
      idx_d = idx_q + BeatIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= burst_q.last_idx)
    else $error("byte index past end of burst");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !at_last) |=> (valid_q && idx_q == $past(idx_q) + BeatIdxW'(1)))
    else $error("byte index did not advance by one");

  a_new_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && idx_q == '0))
    else $error("new burst not started at first byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |-> !load_i)
    else $error("burst overwritten before it was sent");
`endif

endmodule

[design/dle_framer_with_crc8.sv]
// ----------------------------------------------------------------------------
// dle_framer_with_crc8
// DLE/STX/ETX byte-stuffing framer with CRC-8 (poly 0x31) over the payload.
// ----------------------------------------------------------------------------
// An accepted payload byte lands in an input register; from there it is
// expanded in one pass (start pair, stuffed byte, stuffed CRC, end pair) into
// a result register and sent out at one byte per beat. The output port sets
// the rate through its ready. An item causes 1 output byte for a plain
// mid-packet byte, 2 when it equals the escape code, plus 2 on a first byte
// and 3 or 4 on a last byte, at most 8. The next item is taken while the
// current one is still being sent. Codes reset to 0x10, 0x02, 0x03; the user
// must change them only while the stream is idle, and the block itself does
// not enforce this.
module dle_framer_with_crc8
  import dfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  dfc_in_if.sink              in_i,
  dfc_out_if.source           out_o
);

  cfg_t   cfg;
  logic   free;
  logic   load;
  burst_t burst;

  dfc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dfc_frame_build u_frame_build (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_i    (in_i),
    .free_i  (free),
    .load_o  (load),
    .burst_o (burst)
  );

  dfc_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .burst_i (burst),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule
